/* design/b64enc_pkg.sv */
// Package for the streaming Base64 encoder: payload structs, group record,
// padding constants and the sextet-to-ASCII alphabet function.
// No dependencies; every other design file refers to it by scoped names.
package b64enc_pkg;

    // Number of closed groups that may wait between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

    // Number of message bytes carried by a closed group.
    localparam logic [1:0] GROUP_ONE   = 2'd1;
    localparam logic [1:0] GROUP_TWO   = 2'd2;
    localparam logic [1:0] GROUP_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       message_end;
    } out_item_t;

    // A closed group of one to three bytes; bytes not present are zero.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;
        logic       last_group;
    } group_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                c = w + 8'd65;
            end
            else if (v < 6'd52)
            begin
                c = w + 8'd71;
            end
            else if (v < 6'd62)
            begin
                c = w - 8'd4;
            end
            else if (v == 6'd62)
            begin
                c = PLUS_CHAR;
            end
            else
            begin
                c = SLASH_CHAR;
            end
            return c;
        end
    endfunction

endpackage

/* design/b64enc_front.sv */
// Front part of the Base64 encoder: accepts bytes and collects them into groups.
// Uses b64enc_pkg; pushes each closed group into the group queue.
module b64enc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64enc_pkg::in_item_t in_item,
    input  logic                queue_full,
    output logic                push,
    output b64enc_pkg::group_t  push_group
);

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ONE  = 2'd1,
        FILL_TWO  = 2'd2
    } fill_t;

    fill_t      fill_reg;
    fill_t      fill_next;
    logic [7:0] held_first_reg;
    logic [7:0] held_first_next;
    logic [7:0] held_second_reg;
    logic [7:0] held_second_next;
    logic       fire;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        fill_next        = fill_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        push             = 1'b0;
        push_group       = '0;
        push_group.last_group = in_item.final_byte;
        unique case (fill_reg)
            FILL_NONE:
            begin
                push_group.byte0 = in_item.data_byte;
                push_group.count = b64enc_pkg::GROUP_ONE;
                if (fire)
                begin
                    held_first_next = in_item.data_byte;
                    push            = in_item.final_byte;
                    fill_next       = in_item.final_byte ? FILL_NONE : FILL_ONE;
                end
            end
            FILL_ONE:
            begin
                push_group.byte0 = held_first_reg;
                push_group.byte1 = in_item.data_byte;
                push_group.count = b64enc_pkg::GROUP_TWO;
                if (fire)
                begin
                    held_second_next = in_item.data_byte;
                    push             = in_item.final_byte;
                    fill_next        = in_item.final_byte ? FILL_NONE : FILL_TWO;
                end
            end
            FILL_TWO:
            begin
                push_group.byte0 = held_first_reg;
                push_group.byte1 = held_second_reg;
                push_group.byte2 = in_item.data_byte;
                push_group.count = b64enc_pkg::GROUP_THREE;
                if (fire)
                begin
                    push      = 1'b1;
                    fill_next = FILL_NONE;
                end
            end
            default:
            begin
                // An unused fill code behaves as an empty group.
                push_group.byte0 = in_item.data_byte;
                push_group.count = b64enc_pkg::GROUP_ONE;
                if (fire)
                begin
                    held_first_next = in_item.data_byte;
                    push            = in_item.final_byte;
                    fill_next       = in_item.final_byte ? FILL_NONE : FILL_ONE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= FILL_NONE;
            held_first_reg  <= '0;
            held_second_reg <= '0;
        end
        else
        begin
            fill_reg        <= fill_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

endmodule

/* design/b64enc_queue.sv */
// Short queue of closed groups between the front and back parts.
// Uses b64enc_pkg for the group record; depth is set by the Depth parameter.
module b64enc_queue #(
    parameter int unsigned Depth = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64enc_pkg::group_t push_group,
    output logic               full,
    input  logic               pop,
    output b64enc_pkg::group_t pop_group,
    output logic               empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    b64enc_pkg::group_t mem_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_next;
    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;

    assign full      = (count_reg == CntW'(Depth));
    assign empty     = (count_reg == '0);
    assign pop_group = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

/* design/b64enc_back.sv */
// Back part of the Base64 encoder: turns each group into four characters.
// Uses b64enc_pkg; pops groups from the queue and drives the output register.
module b64enc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  b64enc_pkg::group_t    pop_group,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64enc_pkg::out_item_t out_item
);

    b64enc_pkg::group_t    group_reg;
    b64enc_pkg::group_t    group_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [1:0]            idx_reg;
    logic [1:0]            idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    b64enc_pkg::out_item_t out_item_reg;
    b64enc_pkg::out_item_t out_item_next;
    logic                  advance;
    logic [5:0]            sextet;
    logic                  pad;

    // A character moves into the output register when it is empty or draining.
    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign pop     = !queue_empty && (!busy_reg || (advance && idx_reg == 2'd3));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = group_reg.byte0[7:2];
            2'd1:    sextet = {group_reg.byte0[1:0], group_reg.byte1[7:4]};
            2'd2:    sextet = {group_reg.byte1[3:0], group_reg.byte2[7:6]};
            default: sextet = group_reg.byte2[5:0];
        endcase
        pad = ((idx_reg == 2'd2) && (group_reg.count == b64enc_pkg::GROUP_ONE))
            || ((idx_reg == 2'd3) && (group_reg.count != b64enc_pkg::GROUP_THREE));
    end

    always_comb
    begin
        group_next     = group_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_char    = pad ? b64enc_pkg::PAD_CHAR
                                            : b64enc_pkg::sextet_char(sextet);
            out_item_next.run_end     = (idx_reg == 2'd3);
            out_item_next.message_end = (idx_reg == 2'd3) && group_reg.last_group;
            idx_next                  = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            group_next = pop_group;
            busy_next  = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg    <= group_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* design/base64_stream_encoder.sv */
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
// Uses b64enc_pkg and instantiates b64enc_front, b64enc_queue and b64enc_back.
//
// The encoder takes a message one byte per transfer, with final_byte set on
// its last byte, and gives four ASCII characters for every group of three
// bytes; a message that ends on a partial group of one or two bytes gives
// four characters ending in two or one '='. run_end marks the fourth
// character of each group and message_end the last character of the
// message. A byte is taken in every cycle while the group queue has room,
// and characters leave at one per cycle while out_ready is high. The back
// part turns one queued group into one character per cycle, while out_ready
// is high, through a single output register. The byte that closes a group
// is written into the queue, the group then moves into the back part's
// group register, and its first character into the output register. The
// QueueDepth parameter sets how many closed groups may wait between the
// byte side and the character side before the input is held off.
module base64_stream_encoder #(
    parameter int unsigned QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64enc_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64enc_pkg::out_item_t out_item
);

    logic               push;
    b64enc_pkg::group_t push_group;
    logic               queue_full;
    logic               pop;
    b64enc_pkg::group_t pop_group;
    logic               queue_empty;

    // Collects bytes and closes a group on its third byte or on the last byte.
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    // Lets the byte side keep going while the character side is stalled.
    b64enc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .pop_group  (pop_group),
        .empty      (queue_empty)
    );

    // Emits the four characters of each group, one per cycle while out_ready is high.
    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_group   (pop_group),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

/* design/b64enc_checker.sv */
// Port-level checker for the streaming Base64 encoder, bound to the top level.
// Uses b64enc_pkg for the payload types and the padding character.
module b64enc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input b64enc_pkg::in_item_t  in_item,
    input logic                  out_valid,
    input logic                  out_ready,
    input b64enc_pkg::out_item_t out_item
);

    // An offered byte waits with its value held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input transfer changed while waiting");

    // A stalled character holds its place and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output transfer changed while stalled");

    // The end of a message is always the end of a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.message_end |-> out_item.run_end)
    else $error("message_end without run_end");

    // Padding only closes the last group of a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.run_end && out_item.out_char == b64enc_pkg::PAD_CHAR
        |-> out_item.message_end)
    else $error("padding in a group that is not the last one");

    // A padding character inside a group is followed only by more padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.run_end
        && out_item.out_char == b64enc_pkg::PAD_CHAR
        |=> !out_valid || out_item.out_char == b64enc_pkg::PAD_CHAR)
    else $error("data character after padding");

endmodule

bind base64_stream_encoder b64enc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
